>>> src/cdsd_pkg.sv
package cdsd_pkg;

  // default deck and hand geometry
  localparam int unsigned SuitCountDef = 4;
  localparam int unsigned RankCountDef = 13;
  localparam int unsigned HandCardsDef = 5;

  // generator: g = (g * mult + inc) & 0x7fff, only the low 15 bits of mult matter
  localparam int unsigned GenW     = 15;
  localparam int unsigned GenShift = 8;
  localparam int unsigned DrawW    = GenW - GenShift;
  localparam logic [GenW-1:0] GenMult = 15'h4E6D;
  localparam logic [GenW-1:0] GenInc  = 15'h3039;

  // operation codes
  localparam logic [1:0] FuncInit    = 2'd0;
  localparam logic [1:0] FuncShuffle = 2'd1;
  localparam logic [1:0] FuncDeal    = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] seed_value;
  } item_t;

  typedef struct packed {
    logic [1:0] card_suit;
    logic [3:0] card_rank;
    logic       reshuffled;
    logic       last_of_run;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic init;
    logic seed_load;
    logic gen_step;
    logic mod_step;
    logic read_pair;
    logic wr_i;
    logic wr_j;
    logic pos_clear;
    logic deal_read;
    logic deal_emit;
    logic ack_emit;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic shuf_done;
    logic mod_done;
    logic pos_end;
    logic hand_last;
  } dp_stat_t;

endpackage

>>> src/cdsd_ctrl.sv
module cdsd_ctrl import cdsd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic [1:0] func_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy
);

  typedef enum logic [10:0] {
    StIdle  = 11'b000_0000_0001,
    StLoad  = 11'b000_0000_0010,
    StChk   = 11'b000_0000_0100,
    StMod   = 11'b000_0000_1000,
    StRead  = 11'b000_0001_0000,
    StWrI   = 11'b000_0010_0000,
    StWrJ   = 11'b000_0100_0000,
    StDChk  = 11'b000_1000_0000,
    StDRead = 11'b001_0000_0000,
    StDOut  = 11'b010_0000_0000,
    StAck   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   deal_mode_q, deal_mode_d;

  assign busy = (state_q != StIdle);

  always_comb begin
    state_d     = state_q;
    deal_mode_d = deal_mode_q;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          priority if (func_i == FuncInit) begin
            cmd_o.init = 1'b1;
            state_d    = StAck;
          end else if (func_i == FuncShuffle) begin
            deal_mode_d = 1'b0;
            state_d     = StLoad;
          end else if (func_i == FuncDeal) begin
            deal_mode_d = 1'b1;
            state_d     = StDChk;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StLoad: begin
        cmd_o.seed_load = 1'b1;
        state_d         = StChk;
      end
      StChk: begin
        if (stat_i.shuf_done) begin
          state_d = deal_mode_q ? StDRead : StAck;
        end else begin
          cmd_o.gen_step = 1'b1;
          state_d        = StMod;
        end
      end
      StMod: begin
        cmd_o.mod_step = 1'b1;
        if (stat_i.mod_done) begin
          state_d = StRead;
        end
      end
      StRead: begin
        cmd_o.read_pair = 1'b1;
        state_d         = StWrI;
      end
      StWrI: begin
        cmd_o.wr_i = 1'b1;
        state_d    = StWrJ;
      end
      StWrJ: begin
        cmd_o.wr_j = 1'b1;
        state_d    = StChk;
      end
      StDChk: begin
        if (stat_i.pos_end) begin
          cmd_o.pos_clear = 1'b1;
          state_d         = StLoad;
        end else begin
          state_d = StDRead;
        end
      end
      StDRead: begin
        cmd_o.deal_read = 1'b1;
        state_d         = StDOut;
      end
      StDOut: begin
        cmd_o.deal_emit = 1'b1;
        state_d         = stat_i.hand_last ? StIdle : StDChk;
      end
      StAck: begin
        cmd_o.ack_emit = 1'b1;
        state_d        = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      deal_mode_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      deal_mode_q <= deal_mode_d;
    end
  end

endmodule

>>> src/cdsd_datapath.sv
module cdsd_datapath import cdsd_pkg::*; #(
  parameter int unsigned SuitCount = SuitCountDef,
  parameter int unsigned RankCount = RankCountDef,
  parameter int unsigned HandCards = HandCardsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] seed_i,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  output result_t     result_o,
  output logic        result_strobe_o
);

  localparam int unsigned Deck  = SuitCount * RankCount;
  localparam int unsigned IdxW  = (Deck > 1) ? $clog2(Deck) : 1;
  localparam int unsigned PosW  = $clog2(Deck + 1);
  localparam int unsigned CntW  = (HandCards > 1) ? $clog2(HandCards) : 1;
  localparam int unsigned DivW  = DrawW + 1;
  localparam int unsigned StepW = $clog2(DrawW);

  // ordered deck, suit-major, as constant logic
  logic [5:0] order_card [Deck];
  for (genvar k = 0; k < Deck; k++) begin : g_order
    assign order_card[k] = {2'(k / RankCount), 4'(k % RankCount)};
  end

  // deck memory plus one valid bit per entry; invalid entries read as ordered
  logic [5:0] mem [Deck];
  logic [Deck-1:0] valid_q;

  logic [GenW-1:0]  gen_q;
  logic [GenW-1:0]  gen_next;
  logic [GenW-1:0]  gen_prod;
  logic [15:0]      seed_q;
  logic [PosW-1:0]  pos_q;
  logic [IdxW-1:0]  i_q;
  logic [CntW-1:0]  cnt_q;
  logic             resh_q;
  logic [DrawW-1:0] div_v_q;
  logic [DrawW-1:0] rem_q;
  logic [StepW-1:0] step_q;
  logic [DivW-1:0]  divisor;
  logic [DivW-1:0]  rem_shift;
  logic [IdxW-1:0]  j_idx;
  logic [IdxW-1:0]  addr_a;
  logic [IdxW-1:0]  addr_b;
  logic [5:0]       mem_a_q, mem_b_q, ord_a_q, ord_b_q;
  logic             val_a_q, val_b_q;
  logic [5:0]       card_a, card_b;
  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  logic [5:0]       wr_data;

  assign gen_prod = GenW'(gen_q * GenMult);
  assign gen_next = gen_prod + GenInc;

  // restoring remainder, one quotient bit per cycle
  assign divisor   = DivW'(i_q) + DivW'(1);
  assign rem_shift = {rem_q, div_v_q[DrawW-1]};
  assign j_idx     = rem_q[IdxW-1:0];

  assign addr_a = cmd_i.deal_read ? pos_q[IdxW-1:0] : i_q;
  assign addr_b = j_idx;

  assign card_a = val_a_q ? mem_a_q : ord_a_q;
  assign card_b = val_b_q ? mem_b_q : ord_b_q;

  assign wr_en   = cmd_i.wr_i | cmd_i.wr_j;
  assign wr_addr = cmd_i.wr_i ? i_q : j_idx;
  assign wr_data = cmd_i.wr_i ? card_b : card_a;

  assign stat_o.shuf_done = (i_q == '0);
  assign stat_o.mod_done  = (step_q == StepW'(DrawW - 1));
  assign stat_o.pos_end   = (pos_q >= PosW'(Deck));
  assign stat_o.hand_last = (cnt_q == CntW'(HandCards - 1));

  // read data held through both swap writes
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.read_pair | cmd_i.deal_read) begin
      mem_a_q <= mem[addr_a];
      mem_b_q <= mem[addr_b];
      ord_a_q <= order_card[addr_a];
      ord_b_q <= order_card[addr_b];
      val_a_q <= valid_q[addr_a];
      val_b_q <= valid_q[addr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.init) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q  <= '0;
      pos_q  <= '0;
      cnt_q  <= '0;
      resh_q <= 1'b0;
      i_q    <= '0;
      step_q <= '0;
    end else begin
      if (cmd_i.capture) begin
        cnt_q  <= '0;
        resh_q <= 1'b0;
      end
      if (cmd_i.init) begin
        pos_q <= '0;
      end
      if (cmd_i.seed_load) begin
        gen_q <= seed_q[GenW-1:0];
        i_q   <= IdxW'(Deck - 1);
      end
      if (cmd_i.gen_step) begin
        gen_q  <= gen_next;
        step_q <= '0;
      end
      if (cmd_i.mod_step) begin
        step_q <= step_q + StepW'(1);
      end
      if (cmd_i.wr_j) begin
        i_q <= i_q - IdxW'(1);
      end
      if (cmd_i.pos_clear) begin
        pos_q  <= '0;
        resh_q <= 1'b1;
      end
      if (cmd_i.deal_emit) begin
        pos_q  <= pos_q + PosW'(1);
        cnt_q  <= cnt_q + CntW'(1);
        resh_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      seed_q <= seed_i;
    end
    if (cmd_i.gen_step) begin
      div_v_q <= gen_next[GenW-1:GenShift];
      rem_q   <= '0;
    end
    if (cmd_i.mod_step) begin
      div_v_q <= div_v_q << 1;
      if (rem_shift >= divisor) begin
        rem_q <= DrawW'(rem_shift - divisor);
      end else begin
        rem_q <= DrawW'(rem_shift);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_strobe_o <= 1'b0;
    end else begin
      result_strobe_o <= cmd_i.deal_emit | cmd_i.ack_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.deal_emit) begin
      result_o.card_suit   <= card_a[5:4];
      result_o.card_rank   <= card_a[3:0];
      result_o.reshuffled  <= resh_q;
      result_o.last_of_run <= stat_o.hand_last;
    end else if (cmd_i.ack_emit) begin
      result_o <= '{card_suit: 2'd0, card_rank: 4'd0, reshuffled: 1'b0, last_of_run: 1'b1};
    end
  end

endmodule

>>> src/card_deck_shuffle_dealer_top.sv
// init ends in its beat; shuffle runs deck-1 swap steps before its beat
// deal: one beat per card, the first after accept; a deck that runs out
// mid-hand adds a reshuffle before that card
// throughput: one item at a time, set by the swap step (check, remainder
// loop, read and two writes on the single deck memory write port)
// reset: async active low, deck reads as ordered, position and generator cleared
module card_deck_shuffle_dealer_top import cdsd_pkg::*; #(
  parameter int unsigned SuitCount = SuitCountDef,
  parameter int unsigned RankCount = RankCountDef,
  parameter int unsigned HandCards = HandCardsDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  item_t   item_i,
  output logic    busy,
  output result_t result_o,
  output logic    result_strobe_o
);

  // results come as one-cycle beats on result_strobe_o; the receiver cannot stall

  // command and status between controller and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // controller: sequences init, fisher-yates steps and the deal loop
  cdsd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (item_i.func),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // datapath: deck memory, generator, remainder unit, position and hand counters
  cdsd_datapath #(
    .SuitCount (SuitCount),
    .RankCount (RankCount),
    .HandCards (HandCards)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .seed_i          (item_i.seed_value),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .result_o        (result_o),
    .result_strobe_o (result_strobe_o)
  );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cdsd_pkg::*;

  // deck geometry follows the block's default parameters
  localparam int unsigned DeckCards = SuitCountDef * RankCountDef;

  // generator constants, full 32-bit form; the mask keeps only the low 15 bits
  localparam int unsigned LcgMult = 32'd1103515245;
  localparam int unsigned LcgInc  = 32'd12345;

  // the one code the block must ignore
  localparam logic [1:0] FuncUnused = 2'd3;

  // longest quiet stretch: a full reshuffle, the longest sender gap
  // and some margin, taken a few times over
  localparam int unsigned QuietLimit = 4000;

  // cycles to wait after the last beat before the verdict, about one full shuffle
  localparam int unsigned TailCycles = 600;

  localparam int unsigned RandomItems = 345;

  // deck state tracker: mirrors deck, deal position and generator, and holds
  // the cards and acknowledgements still to come out of the block
  class deck_tracker;
    logic [5:0]      deck_cards [DeckCards];
    int unsigned     deal_pos;
    logic [GenW-1:0] gen_q;
    result_t         pending_cards [$];
    int unsigned     mismatches;
    int unsigned     beat_count;

    function new();
      order_deck();
      deal_pos    = 0;
      gen_q       = '0;
      mismatches  = 0;
      beat_count  = 0;
    endfunction

    function void order_deck();
      int unsigned k;
      k = 0;
      for (int unsigned s = 0; s < SuitCountDef; s++) begin
        for (int unsigned r = 0; r < RankCountDef; r++) begin
          deck_cards[k] = {2'(s), 4'(r)};
          k++;
        end
      end
    endfunction

    // fisher-yates pass from the top entry down to entry 1
    function void mix_pass(logic [15:0] seed);
      int unsigned prod;
      int unsigned j;
      logic [5:0]  tmp;
      gen_q = seed[GenW-1:0];
      for (int unsigned i = DeckCards - 1; i > 0; i--) begin
        prod  = int'(gen_q) * LcgMult + LcgInc;
        gen_q = GenW'(prod);
        j     = (int'(gen_q) >> GenShift) % (i + 1);
        tmp           = deck_cards[i];
        deck_cards[i] = deck_cards[j];
        deck_cards[j] = tmp;
      end
    endfunction

    function void take_item(item_t it);
      result_t    beat;
      logic [5:0] card;
      beat = '0;
      case (it.func)
        FuncInit: begin
          order_deck();
          deal_pos = 0;
          beat.last_of_run = 1'b1;
          pending_cards.push_back(beat);
        end
        FuncShuffle: begin
          mix_pass(it.seed_value);
          beat.last_of_run = 1'b1;
          pending_cards.push_back(beat);
        end
        FuncDeal: begin
          for (int unsigned k = 0; k < HandCardsDef; k++) begin
            beat = '0;
            // deck used up: reshuffle with this item's seed before the card
            if (deal_pos >= DeckCards) begin
              deal_pos = 0;
              mix_pass(it.seed_value);
              beat.reshuffled = 1'b1;
            end
            card = deck_cards[deal_pos];
            deal_pos++;
            beat.card_suit   = card[5:4];
            beat.card_rank   = card[3:0];
            beat.last_of_run = (k == HandCardsDef - 1);
            pending_cards.push_back(beat);
          end
        end
        default: begin
        end
      endcase
    endfunction

    task report_mismatch(string what);
      $display("beat %0d: %s", beat_count, what);
      mismatches++;
    endtask

    task check_beat(result_t got);
      result_t want;
      if (pending_cards.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_cards.pop_front();
        if (got.card_suit !== want.card_suit)
          report_mismatch($sformatf("card_suit got %0d expected %0d",
                                    got.card_suit, want.card_suit));
        if (got.card_rank !== want.card_rank)
          report_mismatch($sformatf("card_rank got %0d expected %0d",
                                    got.card_rank, want.card_rank));
        if (got.reshuffled !== want.reshuffled)
          report_mismatch($sformatf("reshuffled got %0b expected %0b",
                                    got.reshuffled, want.reshuffled));
        if (got.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run got %0b expected %0b",
                                    got.last_of_run, want.last_of_run));
      end
      beat_count++;
    endtask
  endclass

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  item_t   item_in;
  logic    busy;
  result_t result_out;
  logic    result_strobe;

  deck_tracker tracker;
  int unsigned quiet_cycles;

  card_deck_shuffle_dealer_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .item_i         (item_in),
    .busy           (busy),
    .result_o       (result_out),
    .result_strobe_o(result_strobe)
  );

  // 2 ns clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result side: every strobed beat is checked against the oldest expectation;
  // sampled at the edge, so the values seen are the ones before the edge
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && result_strobe === 1'b1) begin
      tracker.check_beat(result_out);
    end
  end

  // watchdog: any input beat or result beat restarts the count
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (start === 1'b1 && busy === 1'b0) || result_strobe === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("card_deck_shuffle_dealer_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // present one item and hold it until the block takes it; called at a rising
  // edge, returns at the edge where the beat was accepted with start still high
  task send_item(logic [1:0] func, logic [15:0] seed);
    item_t it;
    it.func       = func;
    it.seed_value = seed;
    start   <= 1'b1;
    item_in <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    tracker.take_item(it);
  endtask

  // sender gap of a given number of cycles
  task hold_off(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // lower start and wait until every expected beat has come out; always
  // returns at a later edge than the one it was called at
  task wait_all_beats();
    start <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_cards.size() != 0);
  endtask

  initial begin
    int unsigned real_items;
    int unsigned burst_len;
    int unsigned pick;
    logic [1:0]  func;
    bit          pressure_done;

    tracker      = new();
    real_items   = 0;
    pressure_done = 1'b0;

    // all inputs known from time zero while reset is held
    rst_ni  <= 1'b0;
    start   <= 1'b0;
    item_in <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    // deal from the reset deck: cards come out in order
    send_item(FuncDeal, 16'h0000);
    // unused code: no beat, no state change
    send_item(FuncUnused, 16'h1234);
    send_item(FuncInit, 16'hFFFF);
    send_item(FuncDeal, 16'hFFFF);
    hold_off(3);
    send_item(FuncShuffle, 16'h0000);
    send_item(FuncDeal, 16'h0000);
    // seed high bit alone gives the same pass as seed zero
    send_item(FuncShuffle, 16'h8000);
    send_item(FuncDeal, 16'h8000);
    send_item(FuncShuffle, 16'h7FFF);
    hold_off(1);
    send_item(FuncShuffle, 16'hFFFF);
    // fresh deck after init, then run it out so the 11th hand reshuffles mid-hand
    send_item(FuncInit, 16'h0000);
    for (int n = 0; n < 11; n++) begin
      send_item(FuncDeal, 16'hA5C3);
      if (n % 4 == 3) hold_off(2);
    end
    send_item(FuncDeal, 16'h5A3C);

    // sender pauses once until the block has nothing left to give
    wait_all_beats();

    // random part: bursts of items with gaps of random length, mostly deals
    // so the deck runs out often and reshuffles land at every card of a hand
    while (real_items < RandomItems) begin
      burst_len = $urandom_range(1, 12);
      repeat (burst_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) func = FuncUnused;
        else if (pick < 10) func = FuncInit;
        else if (pick < 30) func = FuncShuffle;
        else func = FuncDeal;
        send_item(func, 16'($urandom()));
        if (func != FuncUnused) real_items++;
      end
      // some bursts run straight on; long gaps land inside a shuffle pass
      pick = $urandom_range(0, 7);
      if (pick < 2) hold_off($urandom_range(5, 600));
      else if (pick < 6) hold_off($urandom_range(1, 4));
      if (!pressure_done && real_items >= RandomItems / 2) begin
        wait_all_beats();
        pressure_done = 1'b1;
      end
    end

    // drain, then give the block time to show any stray beat
    wait_all_beats();
    repeat (TailCycles) @(posedge clk_i);

    if (tracker.mismatches == 0 && tracker.pending_cards.size() == 0) begin
      $display("card_deck_shuffle_dealer_top: match");
    end else begin
      $display("card_deck_shuffle_dealer_top: mismatch");
    end
    $finish;
  end

endmodule
